>>> hw/rtl/watchdog_key_lock_timer_unit_assert.svh
// ----------------------------------------------------------------------------
// Watchdog assertion macros
// Shorthand for clocked assertions disabled while an active-low reset is asserted.
// ----------------------------------------------------------------------------
`ifndef WATCHDOG_KEY_LOCK_TIMER_UNIT_ASSERT_SVH
`define WATCHDOG_KEY_LOCK_TIMER_UNIT_ASSERT_SVH

// Same-cycle implication: cons must hold whenever ante holds.
`define WKL_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication: cons must hold in the cycle after ante.
`define WKL_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/wkl_pkg.sv
// ----------------------------------------------------------------------------
// Watchdog package
// Field widths, opcodes, register offsets, keys and request/result structs.
// ----------------------------------------------------------------------------
package wkl_pkg;

    localparam int OPCODE_W = 2;
    localparam int OFFSET_W = 12;
    localparam int DATA_W   = 32;

    // Request opcodes; the fourth code is unused and does nothing
    localparam logic [OPCODE_W-1:0] OP_TICK  = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_READ  = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_WRITE = 2'd2;

    // Register byte offsets
    localparam logic [OFFSET_W-1:0] OFS_CTRL   = 12'h000;
    localparam logic [OFFSET_W-1:0] OFS_RELOAD = 12'h004;
    localparam logic [OFFSET_W-1:0] OFS_COUNT  = 12'h008;
    localparam logic [OFFSET_W-1:0] OFS_KEY    = 12'h00C;
    localparam logic [OFFSET_W-1:0] OFS_STATUS = 12'h010;

    // Bit positions
    localparam int BIT_EN_POS    = 0;
    localparam int BIT_INTEN_POS = 1;
    localparam int BIT_TMO_POS   = 0;

    // Key values
    localparam logic [DATA_W-1:0] KEY_FEED  = 32'h5A5A_5A5A;
    localparam logic [DATA_W-1:0] LOCK_WORD = 32'h1ACC_E551;

    localparam logic [DATA_W-1:0] COUNT_ONE = 32'd1;

    typedef struct packed {
        logic [OPCODE_W-1:0] opcode;
        logic [OFFSET_W-1:0] offset;
        logic [DATA_W-1:0]   write_data;
    } t_req;

    typedef struct packed {
        logic [DATA_W-1:0] read_data;
        logic              irq;
    } t_rsp;

endpackage

>>> hw/rtl/wkl_req_if.sv
// ----------------------------------------------------------------------------
// Watchdog request channel
// Valid/ready channel carrying one tick, read or write request.
// ----------------------------------------------------------------------------
interface wkl_req_if;
    import wkl_pkg::*;

    logic                valid;
    logic                ready;
    logic [OPCODE_W-1:0] opcode;
    logic [OFFSET_W-1:0] offset;
    logic [DATA_W-1:0]   write_data;

    modport source (output valid, opcode, offset, write_data, input ready);
    modport sink   (input valid, opcode, offset, write_data, output ready);
endinterface

>>> hw/rtl/wkl_rsp_if.sv
// ----------------------------------------------------------------------------
// Watchdog result channel
// Valid/ready channel carrying read data and the interrupt level.
// ----------------------------------------------------------------------------
interface wkl_rsp_if;
    import wkl_pkg::*;

    logic              valid;
    logic              ready;
    logic [DATA_W-1:0] read_data;
    logic              irq;

    modport source (output valid, read_data, irq, input ready);
    modport sink   (input valid, read_data, irq, output ready);
endinterface

>>> hw/rtl/watchdog_key_lock_timer_unit.sv
// ----------------------------------------------------------------------------
// Watchdog timer with key feed and lock
// Top level: request register, state/update core and result register.
// ----------------------------------------------------------------------------
// The watchdog takes one request per clock cycle on i_req while o_rsp is not
// stalled: a tick, a register read or a register write, and returns exactly
// one result per request on o_rsp, in order. A request sits in the request
// register while the core works on it combinationally, and is loaded into the
// result register as it leaves, where its result waits until o_rsp takes it.
// Throughput is one request per cycle while o_rsp is not stalled: the
// request register refills in the same cycle it drains
// into the result register, and the result register reloads in the cycle its
// result is taken. i_req.ready follows o_rsp.ready combinationally when both
// stages are full. Registers: 0x00 ctrl (bit0 enable, bit1 interrupt enable),
// 0x04 reload, 0x08 count (read only), 0x0C key (0x5A5A5A5A feeds, 0x1ACCE551
// locks ctrl and reload until reset), 0x10 status (bit0 timeout, write one to
// clear). irq on each result is the interrupt level after its request.
// ----------------------------------------------------------------------------
module watchdog_key_lock_timer_unit (
    input  logic      i_clk,
    input  logic      i_rst_n,
    wkl_req_if.sink   i_req,
    wkl_rsp_if.source o_rsp
);
    import wkl_pkg::*;

    // Request held in the input register
    logic in_valid;
    t_req in_req;

    // Result computed by the core for the held request
    t_rsp core_rsp;

    // Room in the result register this cycle
    logic out_space;

    // Move the held request through the core into the result register
    logic advance;

    assign advance = in_valid && out_space;

    // Hold the incoming request
    wkl_in_stage u_in (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (i_req),
        .i_advance(advance),
        .o_valid  (in_valid),
        .o_req    (in_req)
    );

    // Apply the request to the watchdog state and form its result
    wkl_core u_core (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_fire (advance),
        .i_req  (in_req),
        .o_rsp  (core_rsp)
    );

    // Hold the result until the consumer takes it
    wkl_out_stage u_out (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_load (advance),
        .i_rsp  (core_rsp),
        .o_rsp  (o_rsp),
        .o_space(out_space)
    );
endmodule

>>> hw/rtl/wkl_in_stage.sv
// ----------------------------------------------------------------------------
// Watchdog input stage
// Registers one request; refills in the same cycle it is drained.
// ----------------------------------------------------------------------------
module wkl_in_stage (
    input  logic          i_clk,
    input  logic          i_rst_n,
    wkl_req_if.sink       i_req,
    input  logic          i_advance,
    output logic          o_valid,
    output wkl_pkg::t_req o_req
);
    import wkl_pkg::*;

    logic r_valid;
    t_req r_req;
    logic accept;

    assign i_req.ready = !r_valid || i_advance;
    assign accept      = i_req.valid && i_req.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= 1'b1;
        end else if (i_advance) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_req <= '{opcode: i_req.opcode, offset: i_req.offset,
                       write_data: i_req.write_data};
        end
    end

    assign o_valid = r_valid;
    assign o_req   = r_req;
endmodule

>>> hw/rtl/wkl_core.sv
// ----------------------------------------------------------------------------
// Watchdog core
// Holds the watchdog state and applies one request per advance.
// ----------------------------------------------------------------------------
`include "watchdog_key_lock_timer_unit_assert.svh"

module wkl_core (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_fire,
    input  wkl_pkg::t_req i_req,
    output wkl_pkg::t_rsp o_rsp
);
    import wkl_pkg::*;

    logic              r_en, r_inten, r_tmo, r_lock;
    logic [DATA_W-1:0] r_reload, r_count;
    logic              n_en, n_inten, n_tmo, n_lock;
    logic [DATA_W-1:0] n_reload, n_count, n_rd;

    always_comb begin
        n_en     = r_en;
        n_inten  = r_inten;
        n_tmo    = r_tmo;
        n_lock   = r_lock;
        n_reload = r_reload;
        n_count  = r_count;
        n_rd     = '0;
        unique case (i_req.opcode)
            OP_TICK: begin
                if (r_en) begin
                    if (r_tmo) begin
                        n_count = '0;
                    end else if (r_count <= COUNT_ONE) begin
                        n_count = '0;
                        n_tmo   = 1'b1;
                    end else begin
                        n_count = r_count - COUNT_ONE;
                    end
                end
            end
            OP_READ: begin
                unique case (i_req.offset)
                    OFS_CTRL: begin
                        n_rd[BIT_EN_POS]    = r_en;
                        n_rd[BIT_INTEN_POS] = r_inten;
                    end
                    OFS_RELOAD: n_rd = r_reload;
                    OFS_COUNT:  n_rd = r_count;
                    OFS_STATUS: n_rd[BIT_TMO_POS] = r_tmo;
                    default:    n_rd = '0;
                endcase
            end
            OP_WRITE: begin
                unique case (i_req.offset)
                    OFS_CTRL: begin
                        if (!r_lock) begin
                            n_en    = i_req.write_data[BIT_EN_POS];
                            n_inten = i_req.write_data[BIT_INTEN_POS];
                            if (n_en && (r_count == '0)) begin
                                n_count = r_reload;
                            end
                        end
                    end
                    OFS_RELOAD: begin
                        if (!r_lock) begin
                            n_reload = i_req.write_data;
                        end
                    end
                    OFS_KEY: begin
                        if (i_req.write_data == KEY_FEED) begin
                            n_count = r_reload;
                            n_tmo   = 1'b0;
                        end else if (i_req.write_data == LOCK_WORD) begin
                            n_lock = 1'b1;
                        end
                    end
                    OFS_STATUS: begin
                        if (i_req.write_data[BIT_TMO_POS]) begin
                            n_tmo = 1'b0;
                        end
                    end
                    default: ;
                endcase
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_en     <= 1'b0;
            r_inten  <= 1'b0;
            r_tmo    <= 1'b0;
            r_lock   <= 1'b0;
            r_reload <= '0;
            r_count  <= '0;
        end else if (i_fire) begin
            r_en     <= n_en;
            r_inten  <= n_inten;
            r_tmo    <= n_tmo;
            r_lock   <= n_lock;
            r_reload <= n_reload;
            r_count  <= n_count;
        end
    end

    assign o_rsp = '{read_data: n_rd, irq: n_inten & n_tmo};

    `WKL_ASSERT_NEXT(a_lock_sticky, i_clk, i_rst_n, r_lock, r_lock, "lock flag dropped")
    `WKL_ASSERT_NEXT(a_reload_frozen, i_clk, i_rst_n, r_lock, $stable(r_reload),
                     "reload changed while locked")
    `WKL_ASSERT_NOW(a_timeout_at_zero, i_clk, i_rst_n, $rose(r_tmo), r_count == '0,
                    "timeout with nonzero count")
    `WKL_ASSERT_NEXT(a_count_idle, i_clk, i_rst_n, !i_fire, $stable(r_count),
                     "count moved without a request")
endmodule

>>> hw/rtl/wkl_out_stage.sv
// ----------------------------------------------------------------------------
// Watchdog result register
// Holds one result until taken; reloads in the cycle it is taken.
// ----------------------------------------------------------------------------
module wkl_out_stage (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_load,
    input  wkl_pkg::t_rsp i_rsp,
    wkl_rsp_if.source     o_rsp,
    output logic          o_space
);
    import wkl_pkg::*;

    logic r_valid;
    t_rsp r_rsp;

    assign o_space = !r_valid || o_rsp.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_rsp <= i_rsp;
        end
    end

    assign o_rsp.valid     = r_valid;
    assign o_rsp.read_data = r_rsp.read_data;
    assign o_rsp.irq       = r_rsp.irq;
endmodule
